@@ rtl/bpra_pkg.sv @@
// ----------------------------------------------------------------------------
// bpra_pkg
// Shared sizes, codes and types of the bitmap page run allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpra_pkg;

  // Number of page frames held in the occupancy map.
  localparam int FRAMES     = 65536;
  localparam int WORD_BITS  = 64;
  localparam int OFF_W      = 6;
  localparam int LEN_W      = OFF_W + 1;
  localparam int MAP_WORDS  = (FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int FRAME_W    = $clog2(FRAMES);
  localparam int WORD_W     = (FRAME_W > OFF_W) ? FRAME_W - OFF_W : 1;

  // Fixed field widths of the ports.
  localparam int CFG_W      = 17;
  localparam int PAGE_W     = 17;
  localparam int START_W    = 16;
  localparam int GRANT_W    = 16;

  // Frame counters must hold the frame limit itself; sums need one bit more.
  localparam int LIM_W      = (FRAME_W + 1 > CFG_W) ? FRAME_W + 1 : CFG_W;
  localparam int SUM_W      = LIM_W + 1;

  localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = CFG_W'(65536);

  localparam logic OP_ALLOC        = 1'b0;
  localparam logic OP_FREE         = 1'b1;
  localparam logic STATUS_DONE     = 1'b0;
  localparam logic STATUS_NO_SPACE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PASS,
    ST_FETCH,
    ST_SCAN,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_RESULT
  } bpra_state_t;

  // One stretch of equal occupancy bits inside a map word.
  typedef struct packed {
    logic             free;
    logic [LEN_W-1:0] len;
  } bpra_seg_t;

endpackage

`default_nettype wire

@@ rtl/bpra_seg_unit.sv @@
// ----------------------------------------------------------------------------
// bpra_seg_unit
// Measures the stretch of equal occupancy bits that starts at a bit offset.
// ----------------------------------------------------------------------------
`default_nettype none

module bpra_seg_unit (
  input  logic [bpra_pkg::WORD_BITS-1:0] word,
  input  logic [bpra_pkg::OFF_W-1:0]     offset,
  output bpra_pkg::bpra_seg_t            seg
);

  logic [bpra_pkg::WORD_BITS-1:0] shifted;
  logic [bpra_pkg::WORD_BITS-1:0] pattern;
  logic [bpra_pkg::LEN_W-1:0]     ones;
  logic [bpra_pkg::LEN_W-1:0]     room;

  // Zeros shifted in above the word end read as free, so a used stretch stops
  // at the word end by itself and only a free stretch needs clamping to it.
  always_comb begin
    shifted = word >> offset;
    pattern = shifted[0] ? shifted : ~shifted;
    ones    = bpra_pkg::LEN_W'(bpra_pkg::WORD_BITS);
    for (int i = bpra_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (!pattern[i]) begin
        ones = bpra_pkg::LEN_W'(i);
      end
    end
    room     = bpra_pkg::LEN_W'(bpra_pkg::WORD_BITS) - bpra_pkg::LEN_W'(offset);
    seg.free = !shifted[0];
    seg.len  = (ones < room) ? ones : room;
  end

endmodule

`default_nettype wire

@@ rtl/bitmap_page_run_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_page_run_allocator
// Next-fit page frame allocator over a one-bit-per-frame occupancy map.
// ----------------------------------------------------------------------------
// The block keeps one bit per page frame (1 = used) in a 1024 x 64 map memory.
// After reset it sweeps the map to all used, one word per cycle, so no word
// is accepted on the input channel until the sweep is done. The frame_count
// port is always ready, but it must only be written while no word is in
// flight. An allocate word searches from the cursor for the
// lowest run of page_count free frames below the frame limit, retrying once
// from frame 0, and a free word clears a run. Each item is worked on alone,
// paced by the single segment unit and the single map port: an allocate
// walks over one stretch of equal bits at a time, fetching each new map
// word as it reaches it, and then reads and writes back each map word it
// marks; a free reads and writes back each map word it touches. Each item
// also passes entry checks and then hands over its result, which sits in an
// output register so that the next item can start.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_page_run_allocator (
  input  logic                         clk,
  input  logic                         rst,

  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bpra_pkg::CFG_W-1:0]   frame_count,

  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         operation,
  input  logic [bpra_pkg::PAGE_W-1:0]  page_count,
  input  logic [bpra_pkg::START_W-1:0] start_frame,

  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bpra_pkg::GRANT_W-1:0] granted_frame,
  output logic                         status
);

  localparam int LIM_W  = bpra_pkg::LIM_W;
  localparam int SUM_W  = bpra_pkg::SUM_W;
  localparam int WORD_W = bpra_pkg::WORD_W;
  localparam int WB     = bpra_pkg::WORD_BITS;
  localparam int LEN_W  = bpra_pkg::LEN_W;

  // A word mask with bits lo up to, but not including, hi set.
  function automatic logic [WB-1:0] bit_mask(input logic [LEN_W-1:0] lo,
                                            input logic [LEN_W-1:0] hi);
    logic [WB-1:0] m;
    for (int i = 0; i < WB; i++) begin
      m[i] = (LEN_W'(i) >= lo) && (LEN_W'(i) < hi);
    end
    return m;
  endfunction

  // Register state.
  bpra_pkg::bpra_state_t          state, state_next;
  logic [bpra_pkg::CFG_W-1:0]     cfg_frames;
  logic [LIM_W-1:0]               cursor, cursor_next;
  logic [LIM_W-1:0]               scan_frame, scan_frame_next;
  logic [LIM_W-1:0]               run, run_next;
  logic [LIM_W-1:0]               pages, pages_next;
  logic                           retry, retry_next;
  logic [WORD_W-1:0]              rng_word, rng_word_next;
  logic [SUM_W-1:0]               rng_lo, rng_lo_next;
  logic [SUM_W-1:0]               rng_hi, rng_hi_next;
  logic                           mark_set, mark_set_next;
  logic [bpra_pkg::GRANT_W-1:0]   res_frame, res_frame_next;
  logic                           res_status, res_status_next;
  logic [WORD_W-1:0]              clr_addr, clr_addr_next;
  logic                           out_load;

  // Map memory.
  logic [WB-1:0]                  map_mem [bpra_pkg::MAP_WORDS];
  logic [WB-1:0]                  rd_data;
  logic                           mem_re, mem_we;
  logic [WORD_W-1:0]              mem_raddr, mem_waddr;
  logic [WB-1:0]                  mem_wdata;

  // Datapath.
  bpra_pkg::bpra_seg_t            seg;
  logic [LIM_W-1:0]               limit;
  logic [LIM_W-1:0]               avail;
  logic [LIM_W-1:0]               seg_len;
  logic [LIM_W-1:0]               step;
  logic [LIM_W-1:0]               step_frame;
  logic [SUM_W-1:0]               run_sum;
  logic                           hit;
  logic [LIM_W-1:0]               run_start;
  logic [SUM_W-1:0]               free_end;
  logic [SUM_W-1:0]               free_hi;
  logic [SUM_W-1:0]               word_base;
  logic [SUM_W-1:0]               hi_dist;
  logic [LEN_W-1:0]               mask_lo, mask_hi;
  logic [WB-1:0]                  mark_mask;
  logic                           mark_last;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == bpra_pkg::ST_IDLE);

  // The search never reaches past the map, whatever frame_count says.
  assign limit = (LIM_W'(cfg_frames) < LIM_W'(bpra_pkg::FRAMES)) ?
                 LIM_W'(cfg_frames) : LIM_W'(bpra_pkg::FRAMES);

  // The shared segment unit looks at the map word holding the scan frame.
  bpra_seg_unit u_seg (
    .word   (rd_data),
    .offset (scan_frame[bpra_pkg::OFF_W-1:0]),
    .seg    (seg)
  );

  // A stretch is cut short at the frame limit. A free stretch extends the
  // current run; the run is complete once it covers the requested length,
  // and then it started run frames before the stretch.
  assign avail      = limit - scan_frame;
  assign seg_len    = LIM_W'(seg.len);
  assign step       = (seg_len < avail) ? seg_len : avail;
  assign step_frame = scan_frame + step;
  assign run_sum    = SUM_W'(run) + SUM_W'(step);
  assign hit        = seg.free && (run_sum >= SUM_W'(pages));
  assign run_start  = scan_frame - run;

  // A free request stops at the end of the map.
  assign free_end = SUM_W'(start_frame) + SUM_W'(page_count);
  assign free_hi  = (free_end < SUM_W'(bpra_pkg::FRAMES)) ?
                    free_end : SUM_W'(bpra_pkg::FRAMES);

  // Part of the marked range that falls in the current map word.
  assign word_base = SUM_W'(rng_word) << bpra_pkg::OFF_W;
  assign hi_dist   = rng_hi - word_base;
  assign mask_lo   = (rng_lo > word_base) ? LEN_W'(rng_lo - word_base) : '0;
  assign mask_hi   = (hi_dist >= SUM_W'(WB)) ? LEN_W'(WB) : LEN_W'(hi_dist);
  assign mark_mask = bit_mask(mask_lo, mask_hi);
  assign mark_last = (word_base + SUM_W'(WB)) >= rng_hi;

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = rng_word;
    mem_we    = 1'b0;
    mem_waddr = rng_word;
    mem_wdata = mark_set ? (rd_data | mark_mask) : (rd_data & ~mark_mask);
    case (state)
      bpra_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '1;
      end
      bpra_pkg::ST_FETCH: begin
        mem_re    = 1'b1;
        mem_raddr = WORD_W'(scan_frame >> bpra_pkg::OFF_W);
      end
      bpra_pkg::ST_MARK_RD: begin
        mem_re = 1'b1;
      end
      bpra_pkg::ST_MARK_WR: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= map_mem[mem_raddr];
    end
  end

  // Sequencer.
  always_comb begin
    state_next      = state;
    cursor_next     = cursor;
    scan_frame_next = scan_frame;
    run_next        = run;
    pages_next      = pages;
    retry_next      = retry;
    rng_word_next   = rng_word;
    rng_lo_next     = rng_lo;
    rng_hi_next     = rng_hi;
    mark_set_next   = mark_set;
    res_frame_next  = res_frame;
    res_status_next = res_status;
    clr_addr_next   = clr_addr;
    out_load        = 1'b0;

    case (state)
      bpra_pkg::ST_CLEAR: begin
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == WORD_W'(bpra_pkg::MAP_WORDS - 1)) begin
          state_next = bpra_pkg::ST_IDLE;
        end
      end

      bpra_pkg::ST_IDLE: begin
        if (in_valid) begin
          pages_next      = LIM_W'(page_count);
          retry_next      = 1'b0;
          res_frame_next  = '0;
          res_status_next = bpra_pkg::STATUS_DONE;
          if (operation == bpra_pkg::OP_FREE) begin
            rng_lo_next   = SUM_W'(start_frame);
            rng_hi_next   = free_hi;
            rng_word_next = WORD_W'(start_frame >> bpra_pkg::OFF_W);
            mark_set_next = 1'b0;
            state_next    = (SUM_W'(start_frame) < free_hi) ?
                            bpra_pkg::ST_MARK_RD : bpra_pkg::ST_RESULT;
          end else begin
            state_next = bpra_pkg::ST_PASS;
          end
        end
      end

      // Entry checks of one search pass.
      bpra_pkg::ST_PASS: begin
        if ((pages == '0) && (cursor <= limit)) begin
          res_frame_next = bpra_pkg::GRANT_W'(cursor);
          state_next     = bpra_pkg::ST_RESULT;
        end else if ((pages == '0) || (pages > limit) ||
                     (cursor > (limit - pages))) begin
          if (!retry) begin
            retry_next  = 1'b1;
            cursor_next = '0;
          end else begin
            res_status_next = bpra_pkg::STATUS_NO_SPACE;
            state_next      = bpra_pkg::ST_RESULT;
          end
        end else begin
          scan_frame_next = cursor;
          run_next        = '0;
          state_next      = bpra_pkg::ST_FETCH;
        end
      end

      bpra_pkg::ST_FETCH: begin
        state_next = bpra_pkg::ST_SCAN;
      end

      bpra_pkg::ST_SCAN: begin
        if (hit) begin
          res_frame_next = bpra_pkg::GRANT_W'(run_start);
          cursor_next    = run_start + pages;
          rng_lo_next    = SUM_W'(run_start);
          rng_hi_next    = SUM_W'(run_start) + SUM_W'(pages);
          rng_word_next  = WORD_W'(run_start >> bpra_pkg::OFF_W);
          mark_set_next  = 1'b1;
          state_next     = bpra_pkg::ST_MARK_RD;
        end else begin
          scan_frame_next = step_frame;
          run_next        = seg.free ? LIM_W'(run_sum) : '0;
          if (step_frame >= limit) begin
            if (!retry) begin
              retry_next  = 1'b1;
              cursor_next = '0;
              state_next  = bpra_pkg::ST_PASS;
            end else begin
              cursor_next     = limit - pages + 1'b1;
              res_status_next = bpra_pkg::STATUS_NO_SPACE;
              state_next      = bpra_pkg::ST_RESULT;
            end
          end else if ((step_frame >> bpra_pkg::OFF_W) ==
                       (scan_frame >> bpra_pkg::OFF_W)) begin
            state_next = bpra_pkg::ST_SCAN;
          end else begin
            state_next = bpra_pkg::ST_FETCH;
          end
        end
      end

      bpra_pkg::ST_MARK_RD: begin
        state_next = bpra_pkg::ST_MARK_WR;
      end

      bpra_pkg::ST_MARK_WR: begin
        rng_word_next = rng_word + 1'b1;
        state_next    = mark_last ? bpra_pkg::ST_RESULT : bpra_pkg::ST_MARK_RD;
      end

      bpra_pkg::ST_RESULT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = bpra_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = bpra_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bpra_pkg::ST_CLEAR;
      cursor     <= '0;
      cfg_frames <= bpra_pkg::FRAME_COUNT_RESET;
      clr_addr   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      cursor   <= cursor_next;
      clr_addr <= clr_addr_next;
      if (cfg_valid && cfg_ready) begin
        cfg_frames <= frame_count;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_frame <= scan_frame_next;
    run        <= run_next;
    pages      <= pages_next;
    retry      <= retry_next;
    rng_word   <= rng_word_next;
    rng_lo     <= rng_lo_next;
    rng_hi     <= rng_hi_next;
    mark_set   <= mark_set_next;
    res_frame  <= res_frame_next;
    res_status <= res_status_next;
    if (out_load) begin
      granted_frame <= res_frame;
      status        <= res_status;
    end
  end

  // The scan stays below the frame limit and never holds a finished run.
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == bpra_pkg::ST_SCAN) |-> (scan_frame < limit) && (run < pages))
    else $error("scan frame or run length out of range");

  // A marking pass always covers at least one frame.
  a_mark_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == bpra_pkg::ST_MARK_WR) |-> (rng_lo < rng_hi))
    else $error("empty range reached the marking pass");

  // A failed allocate reports frame zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == bpra_pkg::STATUS_NO_SPACE)) |-> (granted_frame == '0))
    else $error("no-space result carries a frame number");

  // An accepted word always starts work, so it cannot be dropped.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != bpra_pkg::ST_IDLE))
    else $error("accepted word did not start work");

  // A result is loaded only when the output register is free or handed over.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

@@ tb/sv/bpra_grant_checker.sv @@
// ----------------------------------------------------------------------------
// bpra_grant_checker
// Watches the allocator's channels, predicts every result and compares it.
// ----------------------------------------------------------------------------
// The checker keeps its own occupancy map, next-fit cursor and frame_count
// copy. Each input word accepted by the block is turned into one expected
// result at once; each accepted result word is compared with the oldest one.
// ----------------------------------------------------------------------------
module bpra_grant_checker import bpra_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CFG_W-1:0]   frame_count,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               operation,
  input  logic [PAGE_W-1:0]  page_count,
  input  logic [START_W-1:0] start_frame,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [GRANT_W-1:0] granted_frame,
  input  logic               status,
  output int                 pending,
  output int                 failures
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [GRANT_W-1:0] frame;
    logic               status;
  } grant_t;

  grant_t      expected_grants[$];
  bit          frame_used [FRAMES];
  int unsigned frame_total;
  int unsigned next_fit;

  function automatic int unsigned frame_limit();
    return (frame_total < FRAMES) ? frame_total : FRAMES;
  endfunction

  // One next-fit pass from the cursor. On success the run is marked used and
  // the cursor moves past it; a pass that walks to the limit parks the cursor
  // just past the last place a run of this length could still start.
  function automatic bit claim_run(input int unsigned pages, output int unsigned first);
    int unsigned lim;
    int unsigned run;
    int unsigned f;
    int unsigned i;
    lim   = frame_limit();
    run   = 0;
    first = 0;
    if (pages > lim) return 1'b0;
    if (pages == 0) begin
      first = next_fit;
      return next_fit <= lim;
    end
    if (next_fit > lim - pages) return 1'b0;
    for (f = next_fit; f < lim; f++) begin
      run = frame_used[f] ? 0 : run + 1;
      if (run == pages) begin
        first = f + 1 - pages;
        for (i = first; i <= f; i++) frame_used[i] = 1'b1;
        next_fit = f + 1;
        return 1'b1;
      end
    end
    next_fit = lim - pages + 1;
    return 1'b0;
  endfunction

  function automatic grant_t predict_grant(input logic op, input int unsigned pages,
                                           input int unsigned base);
    grant_t      g;
    int unsigned first;
    int unsigned f;
    g.frame  = '0;
    g.status = STATUS_DONE;
    if (op == OP_FREE) begin
      // Frames past the end of the map are dropped, not wrapped.
      for (f = base; f < base + pages && f < FRAMES; f++) frame_used[f] = 1'b0;
      return g;
    end
    if (!claim_run(pages, first)) begin
      next_fit = 0;
      if (!claim_run(pages, first)) begin
        g.status = STATUS_NO_SPACE;
        return g;
      end
    end
    g.frame = GRANT_W'(first);
    return g;
  endfunction

  task automatic report_mismatch(input string what);
    failures++;
    $display("%0t ns: grant check: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      expected_grants.delete();
      foreach (frame_used[i]) frame_used[i] = 1'b1;
      frame_total = FRAME_COUNT_RESET;
      next_fit    = 0;
    end else begin
      // The result leaving now always belongs to an older word, so it is
      // checked before this edge's input word is predicted.
      if (out_valid && out_ready) begin
        if (expected_grants.size() == 0) begin
          report_mismatch($sformatf("unexpected result frame %0d status %0d",
                                    granted_frame, status));
        end else begin
          want = expected_grants.pop_front();
          if (granted_frame !== want.frame)
            report_mismatch($sformatf("granted_frame %0d, predicted %0d",
                                      granted_frame, want.frame));
          if (status !== want.status)
            report_mismatch($sformatf("status %0d, predicted %0d", status, want.status));
        end
      end
      if (cfg_valid && cfg_ready) frame_total = frame_count;
      if (in_valid && in_ready)
        expected_grants.push_back(predict_grant(operation, page_count, start_frame));
    end
    pending = expected_grants.size();
  end

endmodule

@@ tb/sv/tb_bitmap_page_run_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_bitmap_page_run_allocator
// Directed and random allocate/free traffic for the page run allocator.
// ----------------------------------------------------------------------------
// The top drives reset, frame_count writes and request words, and lets the
// result channel stall at random. A short directed list covers full-map
// runs, zero-length and oversized requests, wrapped grants and a cursor left
// beyond the frame limit. Random phases then run under a series of
// frame_count settings. All checking is done by bpra_grant_checker.
// ----------------------------------------------------------------------------
module tb_bitmap_page_run_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import bpra_pkg::*;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CFG_W-1:0]   frame_count;
  logic               in_valid;
  logic               in_ready;
  logic               operation;
  logic [PAGE_W-1:0]  page_count;
  logic [START_W-1:0] start_frame;
  logic               out_valid;
  logic               out_ready;
  logic [GRANT_W-1:0] granted_frame;
  logic               status;

  int pending;
  int failures;

  // When steady is set neither side idles. The stimulus asks for a long
  // result-side hold by bumping stall_asks; the receiver process serves it.
  bit steady;
  int stall_asks;
  int stall_served;

  bitmap_page_run_allocator dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .frame_count   (frame_count),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .page_count    (page_count),
    .start_frame   (start_frame),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .granted_frame (granted_frame),
    .status        (status)
  );

  bpra_grant_checker grant_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .frame_count   (frame_count),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .page_count    (page_count),
    .start_frame   (start_frame),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .granted_frame (granted_frame),
    .status        (status),
    .pending       (pending),
    .failures      (failures)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop, so that a run that hangs still ends with an error.
  initial begin
    #60ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: ready drops at random, at odds of 15 in 100, unless the run
  // is in its steady stretch. A requested hold keeps ready low while the
  // sender keeps offering words, so the block backs up and stalls input.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (stall_served != stall_asks) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        stall_served++;
      end
      out_ready <= steady || ($urandom_range(99) >= 15);
    end
  end

  // Offers one request word and returns at the falling edge after it was
  // taken. The caller must then either offer the next word or lower valid
  // in that same step, otherwise the word would be taken twice.
  task automatic send_word(input logic op, input int unsigned pages, input int unsigned first);
    if (!steady && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    page_count  <= PAGE_W'(pages);
    start_frame <= START_W'(first);
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // frame_count is only changed with nothing in flight. Every request word
  // yields exactly one result, so an empty expectation store means idle.
  task automatic set_frame_count(input int unsigned value);
    drain();
    cfg_valid   <= 1'b1;
    frame_count <= CFG_W'(value);
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One random request sized against the current frame limit. Most words are
  // short allocations and frees inside the managed range, which keeps the map
  // fragmented and the cursor moving; the rest are zero-length, oversized or
  // fully random words.
  task automatic random_word(input int unsigned lim);
    int unsigned span;
    int unsigned pick;
    int unsigned pages;
    int unsigned first;
    span = (lim == 0) ? 1 : lim;
    pick = $urandom_range(99);
    if ($urandom_range(99) < 60) begin
      if (pick < 8)       pages = 0;
      else if (pick < 70) pages = $urandom_range(1, 8);
      else if (pick < 88) pages = $urandom_range(9, 64);
      else if (pick < 96) pages = $urandom_range(1, span + 1);
      else                pages = $urandom_range(0, 131071);
      // start_frame carries noise here, since allocation ignores it.
      send_word(OP_ALLOC, pages, $urandom_range(0, 65535));
    end else begin
      if (pick < 90) first = $urandom_range(0, (span > 65536) ? 65535 : span - 1);
      else           first = $urandom_range(0, 65535);
      pick = $urandom_range(99);
      if (pick < 5)       pages = 0;
      else if (pick < 75) pages = $urandom_range(1, 16);
      else if (pick < 95) pages = $urandom_range(17, 128);
      else                pages = $urandom_range(0, 131071);
      send_word(OP_FREE, pages, first);
    end
  endtask

  int unsigned phase_frames [10] = '{1024, 64, 0, 300, 65536, 2048, 131071, 777, 64, 1};
  int unsigned phase_words  [10] = '{100, 90, 20, 90, 30, 100, 30, 100, 90, 30};

  initial begin
    int unsigned lim;
    rst         <= 1'b1;
    cfg_valid   <= 1'b0;
    frame_count <= FRAME_COUNT_RESET;
    in_valid    <= 1'b0;
    operation   <= OP_ALLOC;
    page_count  <= '0;
    start_frame <= '0;
    steady       = 1'b0;
    stall_asks   = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // The whole map starts out used, so the first request fails after two
    // full passes and parks the cursor at the very top of the map.
    send_word(OP_ALLOC, 1, 0);
    // A zero-length grant at cursor 65536 reads back as frame 0.
    send_word(OP_ALLOC, 0, 65535);
    send_word(OP_FREE, 65536, 0);
    // A run covering the whole map, found only by the retry from frame 0.
    send_word(OP_ALLOC, 65536, 65535);
    // Largest page count: only the last frame lies inside the map.
    send_word(OP_FREE, 131071, 65535);
    send_word(OP_ALLOC, 131071, 0);
    send_word(OP_ALLOC, 1, 0);

    set_frame_count(256);
    send_word(OP_FREE, 256, 0);
    send_word(OP_FREE, 0, 16);
    // The cursor now sits beyond the limit; the retry hands out frame 0.
    send_word(OP_ALLOC, 0, 0);
    send_word(OP_ALLOC, 10, 0);
    send_word(OP_ALLOC, 100, 0);
    // This run ends exactly on the last frame below the limit.
    send_word(OP_ALLOC, 146, 0);
    send_word(OP_ALLOC, 1, 0);
    // Frames above frame_count but inside the map are still cleared.
    send_word(OP_FREE, 20, 300);
    send_word(OP_FREE, 30, 50);
    send_word(OP_ALLOC, 30, 0);

    set_frame_count(0);
    send_word(OP_ALLOC, 0, 0);
    send_word(OP_ALLOC, 1, 0);

    // A count above the map size is limited to the map itself.
    set_frame_count(131071);
    send_word(OP_ALLOC, 20, 0);
    send_word(OP_FREE, 1, 0);
    send_word(OP_ALLOC, 1, 0);

    foreach (phase_frames[p]) begin
      set_frame_count(phase_frames[p]);
      lim    = (phase_frames[p] < FRAMES) ? phase_frames[p] : FRAMES;
      steady = (p == 5);
      for (int n = 0; n < phase_words[p]; n++) begin
        if (p == 0 && n == 10) stall_asks++;
        if (p == 3 && n == 40) drain();
        random_word(lim);
      end
    end
    steady = 1'b0;

    drain();
    repeat (100) @(negedge clk);
    if (failures == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
